// ===== hw/rtl/rss_pkg.sv =====
// Shared types and constants for the selected-key record sorter.
package rss_pkg;

    localparam int KEY_W            = 8;
    localparam int POS_W            = 6;
    localparam int SEL_W            = 2;
    localparam int DEFAULT_CAPACITY = 64;

    localparam logic [SEL_W-1:0] SEL_FIRST  = 2'd0;
    localparam logic [SEL_W-1:0] SEL_SECOND = 2'd1;
    localparam logic [SEL_W-1:0] SEL_THIRD  = 2'd2;

    typedef enum logic {
        ST_COLLECT,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] pos;
    } entry_t;

    // Command broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic   insert;
        logic   shift;
        entry_t entry;
    } cell_cmd_t;

endpackage

// ===== hw/rtl/record_sort_by_selected_key.sv =====
// Top level of the selected-key record sorter: controller and chain of cells.
//
// Records arrive on the rec channel (rec_valid / rec_stall) carrying three
// 8-bit scores and a final_record mark. The score chosen by key_select,
// written on the cfg channel (cfg_valid / cfg_ready, always ready), is the
// sort key. Each record is inserted into the chain of CAPACITY cells in parallel:
// each cell compares its key with the new one and either keeps its entry,
// takes its left neighbor's, or takes the new record, so the chain stays in
// ascending order with equal keys in arrival order.
// While collecting, one record is accepted per cycle. The request that
// carries final_record starts the drain: from the next cycle the res channel
// (res_valid / res_stall) presents the stored records from cell 0, one per
// accepted result, with end_of_run on the last. The chain shifts toward cell
// 0 only when a result is taken, so a stalled result holds. rec_stall is high
// until the last record of the run has been taken.
// Records that arrive while the chain is full are dropped.
// Reset empties the chain, returns to collecting and selects the first score.
module record_sort_by_selected_key
    import rss_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [SEL_W-1:0]     key_select,
    input  logic                 rec_valid,
    output logic                 rec_stall,
    input  logic [KEY_W-1:0]     first_score,
    input  logic [KEY_W-1:0]     second_score,
    input  logic [KEY_W-1:0]     third_score,
    input  logic                 final_record,
    output logic                 res_valid,
    input  logic                 res_stall,
    output logic [POS_W-1:0]     record_position,
    output logic [KEY_W-1:0]     key_score,
    output logic                 end_of_run
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    cell_cmd_t          cmd;
    logic [CNT_W-1:0]   count;
    logic               greater [CAPACITY];
    entry_t             entries [CAPACITY];

    rss_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .key_select   (key_select),
        .rec_valid    (rec_valid),
        .rec_stall    (rec_stall),
        .first_score  (first_score),
        .second_score (second_score),
        .third_score  (third_score),
        .final_record (final_record),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .end_of_run   (end_of_run),
        .cmd          (cmd),
        .count        (count)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic   prev_greater;
        entry_t prev_entry;
        entry_t next_entry;

        if (i == 0)
        begin : g_head
            assign prev_greater = 1'b0;
            assign prev_entry   = cmd.entry;
        end
        else
        begin : g_body
            assign prev_greater = greater[i-1];
            assign prev_entry   = entries[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_entry = entries[i];
        end
        else
        begin : g_inner
            assign next_entry = entries[i+1];
        end

        rss_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (i)
        ) u_cell (
            .clk          (clk),
            .cmd          (cmd),
            .count        (count),
            .prev_greater (prev_greater),
            .prev_entry   (prev_entry),
            .next_entry   (next_entry),
            .greater      (greater[i]),
            .entry        (entries[i])
        );
    end

    assign record_position = entries[0].pos;
    assign key_score       = entries[0].key;

endmodule

// ===== hw/rtl/rss_cell.sv =====
// One cell of the sorting chain: holds one entry and trades with its neighbors.
module rss_cell
    import rss_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY,
    parameter int INDEX    = 0
)
(
    input  logic                             clk,
    input  cell_cmd_t                        cmd,
    input  logic [$clog2(CAPACITY+1)-1:0]    count,
    input  logic                             prev_greater,
    input  entry_t                           prev_entry,
    input  entry_t                           next_entry,
    output logic                             greater,
    output entry_t                           entry
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    entry_t entry_reg;
    entry_t entry_next;
    logic   occupied;

    // An empty cell acts as holding a key above every real key.
    assign occupied = count > CNT_W'(INDEX);
    assign greater  = !occupied || (entry_reg.key > cmd.entry.key);
    assign entry    = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.insert && greater)
        begin
            entry_next = prev_greater ? prev_entry : cmd.entry;
        end
        else if (cmd.shift)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== hw/rtl/rss_ctrl.sv =====
// Controller: key selection, fill count and the collect/drain sequence.
module rss_ctrl
    import rss_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [SEL_W-1:0]                 key_select,
    input  logic                             rec_valid,
    output logic                             rec_stall,
    input  logic [KEY_W-1:0]                 first_score,
    input  logic [KEY_W-1:0]                 second_score,
    input  logic [KEY_W-1:0]                 third_score,
    input  logic                             final_record,
    output logic                             res_valid,
    input  logic                             res_stall,
    output logic                             end_of_run,
    output cell_cmd_t                        cmd,
    output logic [$clog2(CAPACITY+1)-1:0]    count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [SEL_W-1:0]   sel_reg;
    logic [KEY_W-1:0]   new_key;
    logic               rec_accept;
    logic               res_accept;

    assign cfg_ready  = 1'b1;
    assign count      = count_reg;
    // Both handshake outputs follow the state register alone.
    assign rec_stall  = (state_reg == ST_DRAIN);
    assign res_valid  = (state_reg == ST_DRAIN);
    assign rec_accept = rec_valid && !rec_stall;
    assign res_accept = res_valid && !res_stall;

    always_comb
    begin
        unique case (sel_reg)
            SEL_FIRST:  new_key = first_score;
            SEL_SECOND: new_key = second_score;
            SEL_THIRD:  new_key = third_score;
            default:    new_key = '0;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        end_of_run      = 1'b0;
        cmd.insert      = 1'b0;
        cmd.shift       = 1'b0;
        cmd.entry.key   = new_key;
        cmd.entry.pos   = POS_W'(count_reg);
        unique case (state_reg)
            ST_COLLECT:
            begin
                if (rec_accept)
                begin
                    // A record that finds the chain full is dropped.
                    if (count_reg < CNT_W'(CAPACITY))
                    begin
                        cmd.insert = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (final_record)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                end_of_run = (count_reg == CNT_W'(1));
                if (res_accept)
                begin
                    cmd.shift  = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                    begin
                        state_next = ST_COLLECT;
                    end
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
            count_reg <= '0;
            sel_reg   <= SEL_FIRST;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                sel_reg <= key_select;
            end
        end
    end

endmodule

// ===== hw/rtl/rss_checker.sv =====
// Port-level checks for the selected-key record sorter, bound to the top level.
module rss_checker
    import rss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rec_valid,
    input  logic                 rec_stall,
    input  logic                 final_record,
    input  logic                 res_valid,
    input  logic                 res_stall,
    input  logic [POS_W-1:0]     record_position,
    input  logic [KEY_W-1:0]     key_score,
    input  logic                 end_of_run
);

    // No record is taken while a sorted run is being delivered.
    a_no_input_during_drain: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid |-> rec_stall
    ) else $error("record accepted while results are pending");

    // A final record starts a run in the next cycle.
    a_final_starts_run: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rec_valid && !rec_stall && final_record) |=> res_valid
    ) else $error("final record did not start a run");

    // The run continues until its last result is taken.
    a_run_continues: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid && !res_stall && !end_of_run) |=> res_valid
    ) else $error("run ended before end_of_run");

    // Nothing follows the last result of a run.
    a_run_ends: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid && !res_stall && end_of_run) |=> !res_valid
    ) else $error("result after end_of_run");

    // A stalled result holds.
    a_stall_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=>
            (res_valid && $stable(record_position) && $stable(key_score)
             && $stable(end_of_run))
    ) else $error("stalled result changed");

endmodule

bind record_sort_by_selected_key rss_checker u_rss_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rec_valid       (rec_valid),
    .rec_stall       (rec_stall),
    .final_record    (final_record),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .record_position (record_position),
    .key_score       (key_score),
    .end_of_run      (end_of_run)
);
